// ===== design/kwm_pkg.sv =====
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int NUM_LISTS   = 8;
    localparam int LIST_DEPTH  = 64;

    localparam int LIST_W      = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CNT_W       = $clog2(NUM_LISTS + 1);
    localparam int PTR_W       = $clog2(2 * LIST_DEPTH);
    localparam int SLOT_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int STORE_WORDS = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [3:0] CFG_LISTS_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         list_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_POP_FIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_push;
        logic do_clear;
        logic do_none;
        logic scan_start;
        logic scan_read;
        logic scan_cmp;
        logic pop_commit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       scan_last;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== design/kwm_ctrl.sv =====
`timescale 1ns / 1ps

module kwm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  kwm_pkg::dp_status_t status,
    output kwm_pkg::dp_cmd_t    cmd
);
    import kwm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.command == CMD_POP)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = status.scan_last ? S_POP_FIN : S_SCAN_RD;
            end
            S_POP_FIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                case (status.command)
                    CMD_PUSH:  cmd.do_push    = 1'b1;
                    CMD_POP:   cmd.scan_start = 1'b1;
                    CMD_CLEAR: cmd.do_clear   = 1'b1;
                    default:   cmd.do_none    = 1'b1;
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
            end
            S_POP_FIN:
            begin
                cmd.pop_commit = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !status.out_free) |=> state_reg == S_RESULT)
        else $error("result state left while output slot busy");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CMP |-> $past(state_reg) == S_SCAN_RD)
        else $error("head compare without preceding head read");

    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(req_valid && req_ready))
        else $error("execute without accepted beat");
`endif

endmodule

// ===== design/kwm_datapath.sv =====
`timescale 1ns / 1ps

module kwm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kwm_pkg::in_item_t   req,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kwm_pkg::out_item_t  rsp,
    input  kwm_pkg::dp_cmd_t    cmd,
    output kwm_pkg::dp_status_t status
);
    import kwm_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * LIST_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(LIST_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= PTR_HALF) ? p - PTR_HALF : p;
        return SLOT_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIST_W-1:0] q,
                                                   input logic [SLOT_W-1:0] s);
        return ADDR_W'(q) * ADDR_W'(LIST_DEPTH) + ADDR_W'(s);
    endfunction

    logic [3:0]         cfg_lists_reg;
    logic [CNT_W-1:0]   used_count;

    in_item_t           item_reg;
    logic [PTR_W-1:0]   rd_ptr_reg [NUM_LISTS];
    logic [PTR_W-1:0]   wr_ptr_reg [NUM_LISTS];
    logic signed [31:0] store_mem [STORE_WORDS];
    logic signed [31:0] mem_rd_reg;

    logic [LIST_W-1:0]  scan_q_reg;
    logic               head_nonempty_reg;
    logic               best_found_reg;
    logic [LIST_W-1:0]  best_q_reg;
    logic signed [31:0] best_val_reg;

    logic signed [31:0] res_value_reg;
    logic [1:0]         res_status_reg;
    logic               rsp_valid_reg;
    out_item_t          rsp_reg;

    logic [LIST_W-1:0]  sel_idx;
    logic [PTR_W-1:0]   sel_rd;
    logic [PTR_W-1:0]   sel_wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               idx_ok;
    logic               list_full;
    logic               push_ok;
    logic               scan_last;
    logic               better;

    always_comb
    begin
        if (cfg_lists_reg == 4'd0)
        begin
            used_count = CNT_W'(1);
        end
        else if (32'(cfg_lists_reg) > NUM_LISTS)
        begin
            used_count = CNT_W'(NUM_LISTS);
        end
        else
        begin
            used_count = CNT_W'(cfg_lists_reg);
        end
    end

    always_comb
    begin
        if (cmd.pop_commit)
        begin
            sel_idx = best_q_reg;
        end
        else if (cmd.scan_read)
        begin
            sel_idx = scan_q_reg;
        end
        else
        begin
            sel_idx = LIST_W'(item_reg.list_index);
        end
    end

    assign sel_rd    = rd_ptr_reg[sel_idx];
    assign sel_wr    = wr_ptr_reg[sel_idx];
    assign rd_addr   = slot_addr(sel_idx, ptr_slot(sel_rd));
    assign wr_addr   = slot_addr(sel_idx, ptr_slot(sel_wr));
    assign idx_ok    = 32'(item_reg.list_index) < NUM_LISTS;
    assign list_full = (sel_wr != sel_rd) && (ptr_slot(sel_wr) == ptr_slot(sel_rd));
    assign push_ok   = idx_ok && !list_full;
    assign scan_last = (32'(scan_q_reg) + 32'd1) >= 32'(used_count);
    assign better    = head_nonempty_reg && (!best_found_reg || mem_rd_reg < best_val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_lists_reg <= CFG_LISTS_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_lists_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
            end
        end
        else if (cmd.do_clear)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
            end
        end
        else if (cmd.do_push && push_ok)
        begin
            wr_ptr_reg[sel_idx] <= ptr_inc(sel_wr);
        end
        else if (cmd.pop_commit && best_found_reg)
        begin
            rd_ptr_reg[sel_idx] <= ptr_inc(sel_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_push && push_ok)
        begin
            store_mem[wr_addr] <= item_reg.value;
        end
        if (cmd.scan_read)
        begin
            mem_rd_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_q_reg        <= '0;
            head_nonempty_reg <= 1'b0;
            best_found_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_q_reg     <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_read)
            begin
                head_nonempty_reg <= (sel_wr != sel_rd);
            end
            if (cmd.scan_cmp)
            begin
                if (better)
                begin
                    best_found_reg <= 1'b1;
                end
                if (!scan_last)
                begin
                    scan_q_reg <= scan_q_reg + LIST_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && better)
        begin
            best_q_reg   <= scan_q_reg;
            best_val_reg <= mem_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
        begin
            res_value_reg  <= '0;
            res_status_reg <= push_ok ? ST_OK : ST_DROPPED;
        end
        else if (cmd.do_clear || cmd.do_none)
        begin
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
        end
        else if (cmd.pop_commit)
        begin
            res_value_reg  <= best_found_reg ? best_val_reg : 32'sd0;
            res_status_reg <= best_found_reg ? ST_OK : ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg.result_value <= res_value_reg;
            rsp_reg.status       <= res_status_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;
    assign status.command   = item_reg.command;
    assign status.scan_last = scan_last;
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

endmodule

// ===== design/k_way_sorted_merge_top.sv =====
// Push, clear and unused commands: execute, then load the result into the output register.
// Pop: scans the heads of the lists in use through the single read port of the value store,
// one list at a time, then pops the smallest; no request is accepted until the result is loaded.
// A waiting result beat in the output register does not stop the next accept.
// rst_n (async, active low) empties all lists and sets lists_in_use to 8.
// Value store contents are not cleared by reset; heads of empty lists are read but not used.
`timescale 1ns / 1ps

module k_way_sorted_merge_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  kwm_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output kwm_pkg::out_item_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);
    import kwm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    kwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    kwm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/sv/k_way_sorted_merge_top_test.sv =====
`timescale 1ns / 1ps

module k_way_sorted_merge_top_test;

    import kwm_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         STALL_CYCLES = 300;
    localparam int         CFG_SETTLE   = 2 * NUM_LISTS + 8;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [3:0] cfg_data;

    k_way_sorted_merge_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // merge model state
    logic signed [31:0] model_store [NUM_LISTS*LIST_DEPTH];
    logic [PTR_W-1:0]   model_rd    [NUM_LISTS];
    logic [PTR_W-1:0]   model_wr    [NUM_LISTS];
    logic [3:0]         model_lists;

    out_item_t merge_expect_q[$];
    out_item_t merge_head;
    int        mismatch_count;
    int        cycle_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    logic      rx_stalled;
    int        tail_val [NUM_LISTS];
    event      start_stall;

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    always begin
        @(start_stall);
        rx_stalled = 1'b1;
        repeat (STALL_CYCLES) @(negedge clk);
        rx_stalled = 1'b0;
    end

    always @(negedge clk) begin
        rsp_ready = !rx_stalled && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (merge_expect_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual value %0d status %0d",
                         $time, rsp.result_value, rsp.status);
                mismatch_count++;
            end
            else begin
                merge_head = merge_expect_q.pop_front();
                if (rsp.result_value !== merge_head.result_value) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, merge_head.result_value, rsp.result_value);
                    mismatch_count++;
                end
                if (rsp.status !== merge_head.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, merge_head.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [2:0] idx,
                                           input logic signed [31:0] val);
        in_item_t it;
        it.command    = cmd;
        it.list_index = idx;
        it.value      = val;
        return it;
    endfunction

    task automatic merge_predict(input in_item_t it, output out_item_t r);
        logic [PTR_W-1:0]   fill;
        int                 span;
        int                 best_q;
        logic               found;
        logic signed [31:0] head;
        logic signed [31:0] best_head;
        r.result_value = '0;
        r.status       = ST_OK;
        found          = 1'b0;
        best_q         = 0;
        best_head      = '0;
        case (it.command)
            CMD_PUSH: begin
                fill = model_wr[it.list_index] - model_rd[it.list_index];
                if (it.list_index >= NUM_LISTS || fill >= LIST_DEPTH) begin
                    r.status = ST_DROPPED;
                end
                else begin
                    model_store[it.list_index*LIST_DEPTH
                                + model_wr[it.list_index][SLOT_W-1:0]] = it.value;
                    model_wr[it.list_index] = model_wr[it.list_index] + 1'b1;
                end
            end
            CMD_POP: begin
                span = int'(model_lists);
                if (span == 0)
                    span = 1;
                if (span > NUM_LISTS)
                    span = NUM_LISTS;
                for (int q = 0; q < span; q++) begin
                    if (model_wr[q] != model_rd[q]) begin
                        head = model_store[q*LIST_DEPTH + model_rd[q][SLOT_W-1:0]];
                        if (!found || head < best_head) begin
                            found     = 1'b1;
                            best_head = head;
                            best_q    = q;
                        end
                    end
                end
                if (found) begin
                    r.result_value  = best_head;
                    model_rd[best_q] = model_rd[best_q] + 1'b1;
                end
                else begin
                    r.status = ST_EMPTY;
                end
            end
            CMD_CLEAR: begin
                for (int q = 0; q < NUM_LISTS; q++) begin
                    model_rd[q] = '0;
                    model_wr[q] = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input in_item_t it);
        out_item_t exp_r;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = it;
        do @(posedge clk); while (!req_ready);
        merge_predict(it, exp_r);
        merge_expect_q = {merge_expect_q, exp_r};
    endtask

    task automatic wait_drain;
        @(negedge clk);
        req_valid = 1'b0;
        while (merge_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_lists(input logic [3:0] lists);
        wait_drain();
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = lists;
        do @(posedge clk); while (!cfg_ready);
        model_lists = lists;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_basic_merge;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        send_item(make_item(CMD_UNUSED, 3'd7, -32'sd1));
        send_item(make_item(CMD_PUSH, 3'd0, 32'sh80000000));
        send_item(make_item(CMD_PUSH, 3'd0, -32'sd1));
        send_item(make_item(CMD_PUSH, 3'd1, 32'sh80000000));
        send_item(make_item(CMD_PUSH, 3'd7, 32'sh7fffffff));
        send_item(make_item(CMD_PUSH, 3'd3, 32'sd0));
        send_item(make_item(CMD_PUSH, 3'd2, -32'sd1));
        repeat (7) send_item(make_item(CMD_POP, 3'd5, 32'sh5a5a5a5a));
        send_item(make_item(CMD_PUSH, 3'd4, 32'sd5));
        send_item(make_item(CMD_CLEAR, 3'd6, 32'sd9));
        send_item(make_item(CMD_POP, 3'd0, 32'sd0));
    endtask

    task automatic test_lists_in_use;
        set_lists(4'd2);
        send_item(make_item(CMD_PUSH, 3'd5, 32'sd100));
        send_item(make_item(CMD_PUSH, 3'd0, 32'sd7));
        send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        set_lists(4'd0);
        send_item(make_item(CMD_PUSH, 3'd1, -32'sd3));
        send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        set_lists(4'd15);
        repeat (3) send_item(make_item(CMD_POP, 3'd0, 32'sd0));
    endtask

    task automatic test_list_full;
        set_lists(4'd1);
        send_item(make_item(CMD_CLEAR, 3'd0, 32'sd0));
        // second round wraps the pointers past twice the depth
        repeat (2) begin
            for (int i = 0; i <= LIST_DEPTH; i++)
                send_item(make_item(CMD_PUSH, 3'd0, 32'(i * 7 - 200)));
            for (int i = 0; i <= LIST_DEPTH; i++)
                send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        end
    endtask

    task automatic test_backpressure;
        set_lists(4'd8);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        -> start_stall;
        for (int i = 0; i < 24; i++)
            send_item(make_item(CMD_PUSH, 3'(i % NUM_LISTS), 32'(i * 3 - 30)));
        for (int i = 0; i < 12; i++)
            send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        wait_drain();
        for (int i = 0; i < 13; i++)
            send_item(make_item(CMD_POP, 3'd0, 32'sd0));
        send_item(make_item(CMD_CLEAR, 3'd0, 32'sd0));
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        in_item_t it;
        int       pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int q = 0; q < NUM_LISTS; q++)
            tail_val[q] = $urandom_range(0, 2000) - 1000;
        for (int n = 0; n < count; n++) begin
            pick          = $urandom_range(0, 99);
            it.list_index = 3'($urandom_range(0, NUM_LISTS - 1));
            it.value      = $urandom;
            if (pick < 2) begin
                it.command = CMD_CLEAR;
                for (int q = 0; q < NUM_LISTS; q++)
                    tail_val[q] = $urandom_range(0, 2000) - 1000;
            end
            else if (pick < 5) begin
                it.command = CMD_UNUSED;
            end
            else if (pick < 55) begin
                it.command = CMD_PUSH;
                // mostly ascending per list, some out-of-order noise
                if ($urandom_range(0, 9) != 0) begin
                    tail_val[it.list_index] = tail_val[it.list_index] + $urandom_range(0, 50);
                    it.value = tail_val[it.list_index];
                end
            end
            else begin
                it.command = CMD_POP;
            end
            send_item(it);
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        rx_stalled     = 1'b0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        mismatch_count = 0;
        model_lists    = CFG_LISTS_RESET;
        for (int q = 0; q < NUM_LISTS; q++) begin
            model_rd[q] = '0;
            model_wr[q] = '0;
        end
        for (int a = 0; a < NUM_LISTS * LIST_DEPTH; a++)
            model_store[a] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_merge();
        test_lists_in_use();
        test_list_full();
        test_backpressure();
        set_lists(4'd8);
        test_random_traffic(170, 32, 68);
        set_lists(4'd5);
        test_random_traffic(170, 68, 32);
        set_lists(4'd10);
        test_random_traffic(170, 0, 0);

        wait_drain();
        repeat (CFG_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/kwm_pkg.sv
design/kwm_ctrl.sv
design/kwm_datapath.sv
design/k_way_sorted_merge_top.sv
tb/sv/k_way_sorted_merge_top_test.sv
